// ===== src/ssa_pkg.sv =====
// Shared types, sizes and codes for the slab slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ssa_pkg;

  localparam int NUM_SLABS      = 8;
  localparam int SLOTS_PER_SLAB = 126;
  localparam int SLOT_BYTES     = 32;
  localparam int SLAB_SIZE      = 4096;

  localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
  localparam int SLAB_SHIFT = $clog2(SLAB_SIZE);
  localparam int SLAB_W     = $clog2(NUM_SLABS);
  localparam int CNT_W      = $clog2(NUM_SLABS + 1);
  localparam int SLOT_W     = SLAB_SHIFT - SLOT_SHIFT;
  localparam int GROUP_BITS = 8;
  localparam int GROUP_W    = $clog2(GROUP_BITS);
  localparam int MAP_GROUPS = (1 << SLOT_W) / GROUP_BITS;
  localparam int GRP_SEL_W  = $clog2(MAP_GROUPS);
  localparam int HALF_GROUPS = MAP_GROUPS / 2;
  localparam int HALF_SEL_W  = $clog2(HALF_GROUPS);
  localparam int MAP_PAD_W  = 1 << SLOT_W;
  localparam int ADDR_W     = 32;
  localparam int LIMIT_W    = 4;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLAB     = 2'd1,
    ST_BAD_ADDR    = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_REGION_BASE = 1'b0,
    REG_SLAB_LIMIT  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic search;
    logic commit;
  } ssa_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } ssa_stat_t;

endpackage

// ===== src/ssa_ctrl.sv =====
// Request sequencer for the slab slot allocator.
// Steps each request through decode, search and commit; uses ssa_pkg.
`timescale 1ns / 1ps

module ssa_ctrl import ssa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ssa_stat_t stat,
  output ssa_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat.out_blocked) begin
          cmd.commit = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? S_DECODE : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.load = in_valid && !in_stall;
  end

endmodule

// ===== src/ssa_datapath.sv =====
// Datapath of the slab slot allocator: configuration, slot bitmaps, use counts,
// partial-slab stack, counters and the result register; uses ssa_pkg.
`timescale 1ns / 1ps

module ssa_datapath import ssa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ssa_cmd_t               cmd,
  output ssa_stat_t              stat,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   func,
  input  logic [ADDR_W-1:0]      addr,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      obj_addr,
  output logic [2:0]             slab_index,
  output logic [6:0]             slot_index,
  output logic [31:0]            allocs_done,
  output logic [31:0]            frees_done
);

  localparam int OFF_SLAB_W = ADDR_W - SLAB_SHIFT;

  logic [ADDR_W-1:0]         region_base;
  logic [LIMIT_W-1:0]        slab_limit;
  logic [SLOTS_PER_SLAB-1:0] slot_maps [NUM_SLABS];
  logic [SLOT_W-1:0]         use_counts [NUM_SLABS];
  logic [SLAB_W-1:0]         partial_stack [NUM_SLABS];
  logic [CNT_W-1:0]          partial_depth;
  logic [CNT_W-1:0]          slabs_opened;
  logic [31:0]               alloc_count;
  logic [31:0]               free_count;

  logic                      func_q;
  logic [ADDR_W-1:0]         addr_q;
  status_t                   pre_status;
  logic                      opened_q;
  logic [SLAB_W-1:0]         slab_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [SLOTS_PER_SLAB-1:0] map_q;
  logic [MAP_GROUPS-1:0]     grp_free_q;
  logic [GROUP_W-1:0]        grp_idx_q [MAP_GROUPS];
  logic                      used_q;

  status_t                   out_status;
  logic [ADDR_W-1:0]         out_addr;
  logic [SLAB_W-1:0]         out_slab;
  logic [SLOT_W-1:0]         out_slot;
  logic [31:0]               out_allocs;
  logic [31:0]               out_frees;

  // Decode.
  logic [LIMIT_W-1:0]    lim;
  logic [ADDR_W-1:0]     off;
  logic [OFF_SLAB_W-1:0] off_slab;
  logic [SLOT_W-1:0]     off_slot;
  logic                  off_bad;
  logic [SLAB_W-1:0]     dec_slab;
  logic [SLOT_W-1:0]     dec_slot;
  logic                  dec_open;
  status_t               dec_status;

  always_comb begin
    lim = (slab_limit > LIMIT_W'(NUM_SLABS)) ? LIMIT_W'(NUM_SLABS) : slab_limit;
    off      = addr_q - region_base;
    off_slab = off[ADDR_W-1:SLAB_SHIFT];
    off_slot = off[SLAB_SHIFT-1:SLOT_SHIFT];
    off_bad  = (off_slab >= OFF_SLAB_W'(slabs_opened)) ||
               (off_slot >= SLOT_W'(SLOTS_PER_SLAB));
    dec_slab   = '0;
    dec_slot   = '0;
    dec_open   = 1'b0;
    dec_status = ST_OK;
    if (func_q == FN_ALLOC) begin
      if (partial_depth == '0) begin
        if (LIMIT_W'(slabs_opened) >= lim) begin
          dec_status = ST_NO_SLAB;
        end else begin
          dec_open = 1'b1;
          dec_slab = slabs_opened[SLAB_W-1:0];
        end
      end else begin
        dec_slab = partial_stack[SLAB_W'(partial_depth - CNT_W'(1))];
      end
    end else begin
      if (off_bad) begin
        dec_status = ST_BAD_ADDR;
      end else begin
        dec_slab = off_slab[SLAB_W-1:0];
        dec_slot = off_slot;
      end
    end
  end

  // Search: lowest free slot within each group of eight.
  logic [MAP_PAD_W-1:0]  map_pad;
  logic [GROUP_BITS-1:0] grp_word;
  logic [MAP_GROUPS-1:0] srch_free;
  logic [GROUP_W-1:0]    srch_idx [MAP_GROUPS];

  always_comb begin
    map_pad = {{(MAP_PAD_W - SLOTS_PER_SLAB){1'b1}}, map_q};
    for (int g = 0; g < MAP_GROUPS; g++) begin
      grp_word     = map_pad[g*GROUP_BITS +: GROUP_BITS];
      srch_free[g] = ~&grp_word;
      srch_idx[g]  = '0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
        if (!grp_word[i]) begin
          srch_idx[g] = GROUP_W'(i);
        end
      end
    end
  end

  // Commit.
  logic [1:0]              half_found;
  logic [HALF_SEL_W-1:0]   half_sel [2];
  logic [GRP_SEL_W-1:0]    grp_sel;
  logic                    slot_found;
  logic [SLOT_W-1:0]       found_slot;
  logic [SLOT_W-1:0]       use_now;
  logic                    was_full;
  logic                    alloc_ok;
  logic                    free_ok;
  logic                    pop_full;
  logic [CNT_W-1:0]        depth_open;
  logic [CNT_W-1:0]        depth_next;
  logic [31:0]             alloc_count_next;
  logic [31:0]             free_count_next;
  status_t                 res_status;
  logic [ADDR_W-1:0]       res_addr;
  logic [SLAB_W-1:0]       res_slab;
  logic [SLOT_W-1:0]       res_slot;

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      half_found[h] = 1'b0;
      half_sel[h]   = '0;
      for (int g = HALF_GROUPS - 1; g >= 0; g--) begin
        if (grp_free_q[h*HALF_GROUPS + g]) begin
          half_found[h] = 1'b1;
          half_sel[h]   = HALF_SEL_W'(g);
        end
      end
    end
    grp_sel    = half_found[0] ? {1'b0, half_sel[0]} : {1'b1, half_sel[1]};
    slot_found = |half_found;
    found_slot = {grp_sel, grp_idx_q[grp_sel]};
    use_now    = use_counts[slab_q];
    was_full   = use_now >= SLOT_W'(SLOTS_PER_SLAB);

    alloc_ok = (func_q == FN_ALLOC) && (pre_status == ST_OK) && slot_found;
    free_ok  = (func_q == FN_FREE) && (pre_status == ST_OK) && used_q;

    depth_open = partial_depth + CNT_W'(opened_q);
    pop_full   = ((use_now + SLOT_W'(1)) >= SLOT_W'(SLOTS_PER_SLAB)) && (depth_open != '0);
    depth_next = partial_depth;
    if (alloc_ok) begin
      depth_next = pop_full ? depth_open - CNT_W'(1) : depth_open;
    end else if (free_ok && was_full && (partial_depth < CNT_W'(NUM_SLABS))) begin
      depth_next = partial_depth + CNT_W'(1);
    end

    alloc_count_next = alloc_ok ? alloc_count + 32'd1 : alloc_count;
    free_count_next  = free_ok ? free_count + 32'd1 : free_count;

    res_status = ST_OK;
    res_addr   = '0;
    res_slab   = '0;
    res_slot   = '0;
    if (func_q == FN_ALLOC) begin
      if (alloc_ok) begin
        res_slab = slab_q;
        res_slot = found_slot;
        res_addr = region_base + (ADDR_W'(slab_q) << SLAB_SHIFT) +
                   (ADDR_W'(found_slot) << SLOT_SHIFT);
      end else begin
        res_status = ST_NO_SLAB;
      end
    end else begin
      if (pre_status != ST_OK) begin
        res_status = pre_status;
      end else begin
        res_slab = slab_q;
        res_slot = slot_q;
        if (!used_q) begin
          res_status = ST_DOUBLE_FREE;
        end
      end
    end
  end

  assign stat.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base   <= '0;
      slab_limit    <= LIMIT_W'(NUM_SLABS);
      partial_depth <= '0;
      slabs_opened  <= '0;
      alloc_count   <= '0;
      free_count    <= '0;
      out_valid     <= 1'b0;
      for (int s = 0; s < NUM_SLABS; s++) begin
        slot_maps[s]  <= '0;
        use_counts[s] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_REGION_BASE: region_base <= cfg_data;
          REG_SLAB_LIMIT:  slab_limit  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        partial_depth <= depth_next;
        alloc_count   <= alloc_count_next;
        free_count    <= free_count_next;
        if (alloc_ok) begin
          slot_maps[slab_q][found_slot] <= 1'b1;
          use_counts[slab_q]            <= use_now + SLOT_W'(1);
          if (opened_q) begin
            slabs_opened <= slabs_opened + CNT_W'(1);
          end
        end
        if (free_ok) begin
          slot_maps[slab_q][slot_q] <= 1'b0;
          if (use_now != '0) begin
            use_counts[slab_q] <= use_now - SLOT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      addr_q <= addr;
    end
    if (cmd.decode) begin
      pre_status <= dec_status;
      opened_q   <= dec_open;
      slab_q     <= dec_slab;
      slot_q     <= dec_slot;
      map_q      <= slot_maps[dec_slab];
    end
    if (cmd.search) begin
      grp_free_q <= srch_free;
      for (int g = 0; g < MAP_GROUPS; g++) begin
        grp_idx_q[g] <= srch_idx[g];
      end
      used_q <= map_pad[slot_q];
    end
    if (cmd.commit) begin
      if (alloc_ok && opened_q) begin
        partial_stack[partial_depth[SLAB_W-1:0]] <= slab_q;
      end else if (free_ok && was_full && (partial_depth < CNT_W'(NUM_SLABS))) begin
        partial_stack[partial_depth[SLAB_W-1:0]] <= slab_q;
      end
      out_status <= res_status;
      out_addr   <= res_addr;
      out_slab   <= res_slab;
      out_slot   <= res_slot;
      out_allocs <= alloc_count_next;
      out_frees  <= free_count_next;
    end
  end

  assign status      = out_status;
  assign obj_addr    = out_addr;
  assign slab_index  = out_slab;
  assign slot_index  = out_slot;
  assign allocs_done = out_allocs;
  assign frees_done  = out_frees;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    partial_depth <= slabs_opened)
    else $error("Partial stack deeper than the number of opened slabs.");

  a_opened_bound: assert property (@(posedge clk) disable iff (rst)
    slabs_opened <= CNT_W'(NUM_SLABS))
    else $error("More slabs opened than exist.");

  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc_ok) |=> (alloc_count == $past(alloc_count) + 32'd1))
    else $error("Successful allocation did not advance the allocation count.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("Result committed over a request still waiting at the output.");

endmodule

// ===== src/slab_slot_allocator_top.sv =====
// Each request passes from acceptance to its result through decode with the bitmap row
// read, a grouped free-slot search, then commit of the state update and the result
// register; a new request is taken in the commit cycle while the output is not stalled,
// so the next request can be accepted while the last one commits. Allocation hands out the
// lowest free slot of the slab on top of the partial-slab stack, opening a new slab when
// the stack is empty; a free maps the address back to slab and slot and reports double
// frees. Configuration must be written only while no request is in flight.
`timescale 1ns / 1ps

module slab_slot_allocator_top import ssa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [ADDR_W-1:0]      addr,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      obj_addr,
  output logic [2:0]             slab_index,
  output logic [6:0]             slot_index,
  output logic [31:0]            allocs_done,
  output logic [31:0]            frees_done
);

  ssa_cmd_t  cmd;
  ssa_stat_t stat;

  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .addr        (addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .obj_addr    (obj_addr),
    .slab_index  (slab_index),
    .slot_index  (slot_index),
    .allocs_done (allocs_done),
    .frees_done  (frees_done)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the slab slot allocator: a ledger class tracks every slab and
// slot and checks each result, while plain tasks drive requests and configuration writes.
// Depends on ssa_pkg and slab_slot_allocator_top only.
`timescale 1ns / 1ps

module tb;
  import ssa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int SLAB_SPAN      = SLOTS_PER_SLAB * SLOT_BYTES;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] obj_addr;
    logic [2:0]  slab;
    logic [6:0]  slot;
    logic [31:0] allocs;
    logic [31:0] frees;
  } alloc_reply_t;

  class slab_ledger;
    logic [31:0] base;
    logic [3:0] limit;
    logic [SLOTS_PER_SLAB-1:0] used_map [NUM_SLABS];
    int unsigned used_cnt [NUM_SLABS];
    int unsigned partial [NUM_SLABS];
    int unsigned depth;
    int unsigned opened;
    logic [31:0] n_alloc;
    logic [31:0] n_free;
    alloc_reply_t replies_due [$];
    int errors, fills, no_slab, bad_addr, dbl_free, alloc_reqs, free_reqs;

    function new();
      base = '0;
      limit = 4'd8;
      for (int i = 0; i < NUM_SLABS; i++) begin
        used_map[i] = '0;
        used_cnt[i] = 0;
        partial[i] = 0;
      end
      depth = 0;
      opened = 0;
      n_alloc = '0;
      n_free = '0;
      errors = 0;
      fills = 0;
      no_slab = 0;
      bad_addr = 0;
      dbl_free = 0;
      alloc_reqs = 0;
      free_reqs = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_REGION_BASE: base = v;
        REG_SLAB_LIMIT: limit = v[3:0];
        default: ;
      endcase
    endfunction

    function alloc_reply_t reply(logic [1:0] st, logic [31:0] a, logic [31:0] sl,
                                 logic [31:0] so);
      alloc_reply_t r;
      r.status = st;
      r.obj_addr = a;
      r.slab = sl[2:0];
      r.slot = so[6:0];
      r.allocs = n_alloc;
      r.frees = n_free;
      return r;
    endfunction

    function alloc_reply_t take_slot();
      int unsigned lim, slab, slot;
      int s;
      bit fresh;
      lim = (limit < NUM_SLABS) ? limit : NUM_SLABS;
      fresh = (depth == 0);
      if (fresh && opened >= lim) begin
        no_slab++;
        return reply(ST_NO_SLAB, '0, 0, 0);
      end
      slab = (fresh ? opened : partial[depth - 1]) % NUM_SLABS;
      slot = SLOTS_PER_SLAB;
      for (s = SLOTS_PER_SLAB - 1; s >= 0; s--) begin
        if (!used_map[slab][s]) slot = s;
      end
      if (slot >= SLOTS_PER_SLAB) begin
        no_slab++;
        return reply(ST_NO_SLAB, '0, 0, 0);
      end
      if (fresh) begin
        partial[depth] = slab;
        depth++;
        opened++;
      end
      used_map[slab][slot] = 1'b1;
      used_cnt[slab]++;
      n_alloc++;
      if (used_cnt[slab] >= SLOTS_PER_SLAB && depth > 0) begin
        depth--;
        fills++;
      end
      return reply(ST_OK, base + slab * SLAB_SIZE + slot * SLOT_BYTES, slab, slot);
    endfunction

    function alloc_reply_t return_slot(logic [31:0] a);
      logic [31:0] off, slab, slot;
      off = a - base;
      slab = off / SLAB_SIZE;
      slot = (off % SLAB_SIZE) / SLOT_BYTES;
      if (slab >= opened || slab >= NUM_SLABS || slot >= SLOTS_PER_SLAB) begin
        bad_addr++;
        return reply(ST_BAD_ADDR, '0, 0, 0);
      end
      if (!used_map[slab][slot]) begin
        dbl_free++;
        return reply(ST_DOUBLE_FREE, '0, slab, slot);
      end
      used_map[slab][slot] = 1'b0;
      if (used_cnt[slab] >= SLOTS_PER_SLAB && depth < NUM_SLABS) begin
        partial[depth] = slab;
        depth++;
      end
      if (used_cnt[slab] > 0) used_cnt[slab]--;
      n_free++;
      return reply(ST_OK, '0, slab, slot);
    endfunction

    function void note_request(func_t f, logic [31:0] a);
      if (f == FN_ALLOC) begin
        alloc_reqs++;
        replies_due.push_back(take_slot());
      end else begin
        free_reqs++;
        replies_due.push_back(return_slot(a));
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(alloc_reply_t got);
      alloc_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("obj_addr", want.obj_addr, got.obj_addr);
      compare_field("slab_index", want.slab, got.slab);
      compare_field("slot_index", want.slot, got.slot);
      compare_field("allocs_done", want.allocs, got.allocs);
      compare_field("frees_done", want.frees, got.frees);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Address of a random slot that is in use (or free), with a random offset inside it.
    function logic [31:0] slot_address(bit want_used);
      int unsigned n, start, idx, k, sl, st;
      n = (opened < NUM_SLABS) ? opened : NUM_SLABS;
      if (n == 0) return base;
      start = $urandom_range(n * SLOTS_PER_SLAB - 1, 0);
      for (k = 0; k < n * SLOTS_PER_SLAB; k++) begin
        idx = (start + k) % (n * SLOTS_PER_SLAB);
        sl = idx / SLOTS_PER_SLAB;
        st = idx % SLOTS_PER_SLAB;
        if (used_map[sl][st] == want_used)
          return base + sl * SLAB_SIZE + st * SLOT_BYTES
                 + ($urandom_range(1, 0) ? $urandom_range(SLOT_BYTES - 1, 0) : 0);
      end
      return base;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_func;
  logic [31:0] req_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] obj_addr;
  logic [2:0]  slab_index;
  logic [6:0]  slot_index;
  logic [31:0] allocs_done;
  logic [31:0] frees_done;

  slab_ledger   ledger;
  alloc_reply_t seen;
  int           results_seen;
  int           quiet;
  int           burst_left;

  slab_slot_allocator_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(req_func),
    .addr(req_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .obj_addr(obj_addr),
    .slab_index(slab_index),
    .slot_index(slot_index),
    .allocs_done(allocs_done),
    .frees_done(frees_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.status = status;
        seen.obj_addr = obj_addr;
        seen.slab = slab_index;
        seen.slot = slot_index;
        seen.allocs = allocs_done;
        seen.frees = frees_done;
        ledger.check_result(seen);
        results_seen++;
      end
      if (in_valid && !in_stall) ledger.note_request(func_t'(req_func), req_addr);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // The receiver changes its stall pattern at random, and once holds off
  // for a long stretch so that the allocator fills up and stalls its requests.
  initial begin
    int mode, left;
    bit held;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(3, 0);
        left = $urandom_range(80, 20);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(1, 0);
        2: out_stall <= left[0];
        default: out_stall <= (left % 4 != 0);
      endcase
    end
  end

  task automatic write_register(input reg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    ledger.set_register(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_request(input func_t f, input logic [31:0] a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    req_func <= f;
    req_addr <= a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int alloc_pct);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < alloc_pct) begin
        send_request(FN_ALLOC, $urandom());
      end else begin
        case ($urandom_range(9, 0))
          7: a = ledger.slot_address(1'b0);
          8: a = $urandom();
          9: begin
            case ($urandom_range(2, 0))
              0: a = ledger.base + $urandom_range(NUM_SLABS - 1, 0) * SLAB_SIZE
                     + SLAB_SPAN + $urandom_range(SLAB_SIZE - SLAB_SPAN - 1, 0);
              1: a = ledger.base - $urandom_range(SLAB_SIZE, 1);
              default: a = ledger.base + $urandom_range(NUM_SLABS, ledger.opened) * SLAB_SIZE
                           + $urandom_range(SLAB_SIZE - 1, 0);
            endcase
          end
          default: a = ledger.slot_address(1'b1);
        endcase
        send_request(FN_FREE, a);
      end
    end
  endtask

  initial begin
    logic [31:0] b;
    ledger = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_REGION_BASE;
    cfg_data = '0;
    in_valid = 1'b0;
    req_func = FN_ALLOC;
    req_addr = '0;
    results_seen = 0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // No slab may be opened: allocation fails and every free misses.
    b = 32'hFFFF_F000;
    write_register(REG_SLAB_LIMIT, 32'd0);
    write_register(REG_REGION_BASE, b);
    send_request(FN_ALLOC, '0);
    send_request(FN_FREE, b);
    send_request(FN_FREE, 32'h0000_0000);
    settle();

    // One slab: unaligned, double, wrapped, tail and out-of-range frees.
    write_register(REG_SLAB_LIMIT, 32'd1);
    send_request(FN_ALLOC, '0);
    send_request(FN_ALLOC, '0);
    send_request(FN_ALLOC, '0);
    send_request(FN_FREE, b + SLOT_BYTES + 5);
    send_request(FN_FREE, b + SLOT_BYTES);
    send_request(FN_FREE, b - 4);
    send_request(FN_FREE, b + SLAB_SPAN);
    send_request(FN_FREE, b + SLAB_SIZE);
    send_request(FN_FREE, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 32'hFFFF_FFFF);
    send_request(FN_FREE, 32'h0000_0000);
    send_request(FN_FREE, b + 2 * SLOT_BYTES + SLOT_BYTES - 1);

    // Mostly allocation, so that the slab fills, pops and is pushed back by frees.
    random_phase(200, 85);
    settle();

    write_register(REG_REGION_BASE, 32'hFFFF_FFFF);
    write_register(REG_SLAB_LIMIT, 32'd3);
    random_phase(180, 75);
    settle();

    write_register(REG_SLAB_LIMIT, 32'd15);
    write_register(REG_REGION_BASE, $urandom());
    random_phase(100, 50);
    settle();

    write_register(REG_REGION_BASE, 32'd0);
    write_register(REG_SLAB_LIMIT, {28'($urandom_range(32'h0FFF_FFFF, 1)), 4'd8});
    random_phase(60, 40);
    settle();

    $display("Run covered %0d allocation and %0d free requests; %0d slabs opened, %0d fills.",
             ledger.alloc_reqs, ledger.free_reqs, ledger.opened, ledger.fills);
    $display("Failures seen: %0d with no slab, %0d bad addresses, %0d double frees.",
             ledger.no_slab, ledger.bad_addr, ledger.dbl_free);
    if (ledger.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ssa_pkg.sv
src/ssa_ctrl.sv
src/ssa_datapath.sv
src/slab_slot_allocator_top.sv
tb/tb.sv
